### hw/rtl/blic_pkg.sv
// ----------------------------------------------------------------------------
// blic_pkg
// shared types, field widths, defaults and the class label lookup of the
// binary image linear classifier
// ----------------------------------------------------------------------------
package blic_pkg;

	// default geometry
	localparam int IMAGE_WIDTH_DEF  = 12;
	localparam int IMAGE_HEIGHT_DEF = 24;
	localparam int NUM_CLASSES_DEF  = 34;

	// fixed field widths
	localparam int OP_W    = 2;
	localparam int PIX_W   = 9;
	localparam int CLS_W   = 6;
	localparam int VAL_W   = 16;
	localparam int LABEL_W = 7;
	localparam int ACC_W   = 26;
	localparam int SCORE_W = 27;

	// stream word widths
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 16;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD_WEIGHT = 2'd0,
		OP_LOAD_BIAS   = 2'd1,
		OP_PIXEL       = 2'd2
	} op_t;

	// one issue slot of the sequencer
	typedef struct packed {
		logic             issue;
		logic             score;
		logic [CLS_W-1:0] cls;
	} step_t;

	// accumulator write back
	typedef struct packed {
		logic                    en;
		logic [CLS_W-1:0]        cls;
		logic signed [ACC_W-1:0] data;
	} acc_wr_t;

	// ascii anchors of the label alphabet
	localparam logic [LABEL_W-1:0] CH_0 = 7'h30;
	localparam logic [LABEL_W-1:0] CH_9 = 7'h39;
	localparam logic [LABEL_W-1:0] CH_A = 7'h41;
	localparam logic [LABEL_W-1:0] CH_H = 7'h48;
	localparam logic [LABEL_W-1:0] CH_J = 7'h4A;
	localparam logic [LABEL_W-1:0] CH_N = 7'h4E;
	localparam logic [LABEL_W-1:0] CH_P = 7'h50;
	localparam logic [LABEL_W-1:0] CH_Z = 7'h5A;

	// last class code of the digit run and of each run of letters
	localparam int CODE_9 = int'(CH_9) - int'(CH_0);
	localparam int CODE_H = CODE_9 + 1 + int'(CH_H) - int'(CH_A);
	localparam int CODE_N = CODE_H + 1 + int'(CH_N) - int'(CH_J);
	localparam int CODE_Z = CODE_N + 1 + int'(CH_Z) - int'(CH_P);

	// digits, then letters without I and O, zero past the alphabet
	function automatic logic [LABEL_W-1:0] label_of(input logic [CLS_W-1:0] code);
		logic [LABEL_W-1:0] c;
		begin
			c = LABEL_W'(code);
			if (c <= LABEL_W'(CODE_9))
				return CH_0 + c;
			else if (c <= LABEL_W'(CODE_H))
				return CH_A + c - LABEL_W'(CODE_9 + 1);
			else if (c <= LABEL_W'(CODE_N))
				return CH_J + c - LABEL_W'(CODE_H + 1);
			else if (c <= LABEL_W'(CODE_Z))
				return CH_P + c - LABEL_W'(CODE_N + 1);
			else
				return '0;
		end
	endfunction

endpackage

### hw/rtl/binary_image_linear_classifier_unit.sv
// ----------------------------------------------------------------------------
// binary_image_linear_classifier_unit
// single-layer linear classifier over a binarized character image, argmax out
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries load and pixel words. tuser selects the kind: load weight,
//   load bias or image pixel; tlast marks the final pixel of an image.
//   weights and biases are signed q4.12 and must be loaded before use.
//   m_axis carries one word per image: class code and its ascii label.
// sequencing:
//   a load word, a cleared pixel, or a pixel outside the image leaves the
//   sequencer idle for the next word, unless it is the last pixel. a set
//   pixel runs one class per cycle through the single shared adder that
//   updates the accumulator memory.
//   on the last pixel a scoring pass adds each bias and tracks the running
//   maximum; the fin and emit states then load the result word into the
//   output register once it is free.
// reset: accumulators read as zero, no result pending; tables keep no value.
// stall: a waiting result does not block new words; only a second result
//   waits in the emit state until the output register is free.
// ----------------------------------------------------------------------------
module binary_image_linear_classifier_unit #(
	parameter int IMAGE_WIDTH  = blic_pkg::IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = blic_pkg::IMAGE_HEIGHT_DEF,
	parameter int NUM_CLASSES  = blic_pkg::NUM_CLASSES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input words
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// pixel_index[8:0], class_index[14:9], value[30:15], pixel[31]
	input  logic [blic_pkg::S_DATA_W-1:0]   s_axis_tdata,
	// operation[1:0]
	input  logic [blic_pkg::OP_W-1:0]       s_axis_tuser,
	// last_pixel
	input  logic                            s_axis_tlast,
	// result words
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// class_code[5:0], label_char[12:6], zero[15:13]
	output logic [blic_pkg::M_DATA_W-1:0]   m_axis_tdata
);
	import blic_pkg::*;

	localparam int NPIX = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int CW   = $clog2(NUM_CLASSES);
	localparam int WA   = $clog2(NPIX * NUM_CLASSES);

	// unpacked input word
	logic                    accept;
	op_t                     op;
	logic [PIX_W-1:0]        pixel_index;
	logic [CLS_W-1:0]        class_index;
	logic signed [VAL_W-1:0] value;
	logic                    pixel;

	// sequencer to storage and adder
	logic                    wld_en;
	logic [WA-1:0]           wld_addr;
	logic                    bld_en;
	logic [CW-1:0]           bld_addr;
	step_t                   step;
	logic [WA-1:0]           waddr;
	logic                    emit;
	logic                    out_free;

	// storage read data and write back
	logic signed [ACC_W-1:0] acc_rd;
	logic signed [VAL_W-1:0] weight_rd;
	logic signed [VAL_W-1:0] bias_rd;
	acc_wr_t                 acc_wr;
	logic [CLS_W-1:0]        best_cls;

	// output register
	logic                    out_vld_q;
	logic [CLS_W-1:0]        code_q;
	logic [LABEL_W-1:0]      label_q;

	assign accept      = s_axis_tvalid && s_axis_tready;
	assign op          = op_t'(s_axis_tuser);
	assign pixel_index = s_axis_tdata[PIX_W-1:0];
	assign class_index = s_axis_tdata[PIX_W+CLS_W-1:PIX_W];
	assign value       = s_axis_tdata[PIX_W+CLS_W+VAL_W-1:PIX_W+CLS_W];
	assign pixel       = s_axis_tdata[PIX_W+CLS_W+VAL_W];

	// the result register frees up in the same cycle it is taken
	assign out_free = !out_vld_q || m_axis_tready;

	blic_ctrl #(
		.IMAGE_WIDTH  (IMAGE_WIDTH),
		.IMAGE_HEIGHT (IMAGE_HEIGHT),
		.NUM_CLASSES  (NUM_CLASSES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.op          (op),
		.pixel_index (pixel_index),
		.class_index (class_index),
		.pixel       (pixel),
		.last_pixel  (s_axis_tlast),
		.out_free    (out_free),
		.ready       (s_axis_tready),
		.wld_en      (wld_en),
		.wld_addr    (wld_addr),
		.bld_en      (bld_en),
		.bld_addr    (bld_addr),
		.step        (step),
		.waddr       (waddr),
		.emit        (emit)
	);

	blic_mem #(
		.IMAGE_WIDTH  (IMAGE_WIDTH),
		.IMAGE_HEIGHT (IMAGE_HEIGHT),
		.NUM_CLASSES  (NUM_CLASSES)
	) u_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.wld_en    (wld_en),
		.wld_addr  (wld_addr),
		.bld_en    (bld_en),
		.bld_addr  (bld_addr),
		.value     (value),
		.step      (step),
		.waddr     (waddr),
		.acc_wr    (acc_wr),
		.acc_clr   (emit),
		.acc_rd    (acc_rd),
		.weight_rd (weight_rd),
		.bias_rd   (bias_rd)
	);

	blic_alu u_alu (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.acc_rd    (acc_rd),
		.weight_rd (weight_rd),
		.bias_rd   (bias_rd),
		.acc_wr    (acc_wr),
		.best_cls  (best_cls)
	);

	// result register, loaded only when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (emit)
			out_vld_q <= 1'b1;
		else if (m_axis_tready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			code_q  <= best_cls;
			label_q <= label_of(best_cls);
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {(M_DATA_W-CLS_W-LABEL_W)'(0), label_q, code_q};

endmodule

### hw/rtl/blic_mem.sv
// ----------------------------------------------------------------------------
// blic_mem
// weight, bias and accumulator storage with registered reads
// ----------------------------------------------------------------------------
module blic_mem #(
	parameter int IMAGE_WIDTH  = blic_pkg::IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = blic_pkg::IMAGE_HEIGHT_DEF,
	parameter int NUM_CLASSES  = blic_pkg::NUM_CLASSES_DEF,
	localparam int NPIX = IMAGE_WIDTH * IMAGE_HEIGHT,
	localparam int CW   = $clog2(NUM_CLASSES),
	localparam int WA   = $clog2(NPIX * NUM_CLASSES)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// load port
	input  logic                                 wld_en,
	input  logic [WA-1:0]                        wld_addr,
	input  logic                                 bld_en,
	input  logic [CW-1:0]                        bld_addr,
	input  logic signed [blic_pkg::VAL_W-1:0]    value,
	// sequencer reads
	input  blic_pkg::step_t                      step,
	input  logic [WA-1:0]                        waddr,
	// accumulator write back and clear
	input  blic_pkg::acc_wr_t                    acc_wr,
	input  logic                                 acc_clr,
	// read data, registered on issue and valid in the cycle after
	output logic signed [blic_pkg::ACC_W-1:0]    acc_rd,
	output logic signed [blic_pkg::VAL_W-1:0]    weight_rd,
	output logic signed [blic_pkg::VAL_W-1:0]    bias_rd
);
	import blic_pkg::*;

	logic signed [VAL_W-1:0] weight_mem [NPIX*NUM_CLASSES];
	logic signed [VAL_W-1:0] bias_mem [NUM_CLASSES];
	logic signed [ACC_W-1:0] acc_mem [NUM_CLASSES];
	logic [NUM_CLASSES-1:0]  acc_vld_q;

	logic signed [ACC_W-1:0] acc_rd_s1;
	logic                    acc_rvld_s1;

	always_ff @(posedge clk) begin
		if (wld_en)
			weight_mem[wld_addr] <= value;
		if (step.issue)
			weight_rd <= weight_mem[waddr];
	end

	always_ff @(posedge clk) begin
		if (bld_en)
			bias_mem[bld_addr] <= value;
		if (step.issue)
			bias_rd <= bias_mem[step.cls[CW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (acc_wr.en)
			acc_mem[acc_wr.cls[CW-1:0]] <= acc_wr.data;
		if (step.issue)
			acc_rd_s1 <= acc_mem[step.cls[CW-1:0]];
	end

	// an entry never written since the last clear reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_q   <= '0;
			acc_rvld_s1 <= 1'b0;
		end else begin
			if (acc_clr)
				acc_vld_q <= '0;
			else if (acc_wr.en)
				acc_vld_q[acc_wr.cls[CW-1:0]] <= 1'b1;
			if (step.issue)
				acc_rvld_s1 <= acc_vld_q[step.cls[CW-1:0]];
		end
	end

	assign acc_rd = acc_rvld_s1 ? acc_rd_s1 : '0;

endmodule

### hw/rtl/blic_alu.sv
// ----------------------------------------------------------------------------
// blic_alu
// shared adder with saturation for accumulation and running argmax for scores
// ----------------------------------------------------------------------------
module blic_alu (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  blic_pkg::step_t                      step,
	input  logic signed [blic_pkg::ACC_W-1:0]    acc_rd,
	input  logic signed [blic_pkg::VAL_W-1:0]    weight_rd,
	input  logic signed [blic_pkg::VAL_W-1:0]    bias_rd,
	output blic_pkg::acc_wr_t                    acc_wr,
	output logic [blic_pkg::CLS_W-1:0]           best_cls
);
	import blic_pkg::*;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	step_t                     step_s1;
	logic signed [VAL_W-1:0]   operand;
	logic signed [SCORE_W-1:0] sum;
	logic signed [ACC_W-1:0]   sat;
	logic                      better;
	logic signed [SCORE_W-1:0] best_q;
	logic [CLS_W-1:0]          best_cls_q;

	always_comb begin
		operand = step_s1.score ? bias_rd : weight_rd;
		sum     = SCORE_W'(acc_rd) + SCORE_W'(operand);
		// overflow when the two top bits disagree
		if (sum[SCORE_W-1] != sum[SCORE_W-2])
			sat = sum[SCORE_W-1] ? ACC_MIN : ACC_MAX;
		else
			sat = sum[ACC_W-1:0];
		acc_wr.en   = step_s1.issue && !step_s1.score;
		acc_wr.cls  = step_s1.cls;
		acc_wr.data = sat;
		// strict greater keeps the lowest index on a tie
		better = (step_s1.cls == '0) || (sum > best_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_s1 <= '0;
		else
			step_s1 <= step;
	end

	always_ff @(posedge clk) begin
		if (step_s1.issue && step_s1.score && better) begin
			best_q     <= sum;
			best_cls_q <= step_s1.cls;
		end
	end

	assign best_cls = best_cls_q;

endmodule

### hw/rtl/blic_ctrl.sv
// ----------------------------------------------------------------------------
// blic_ctrl
// item decode and class sequencer
// ----------------------------------------------------------------------------
module blic_ctrl #(
	parameter int IMAGE_WIDTH  = blic_pkg::IMAGE_WIDTH_DEF,
	parameter int IMAGE_HEIGHT = blic_pkg::IMAGE_HEIGHT_DEF,
	parameter int NUM_CLASSES  = blic_pkg::NUM_CLASSES_DEF,
	localparam int NPIX = IMAGE_WIDTH * IMAGE_HEIGHT,
	localparam int CW   = $clog2(NUM_CLASSES),
	localparam int WA   = $clog2(NPIX * NUM_CLASSES)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 accept,
	input  blic_pkg::op_t                        op,
	input  logic [blic_pkg::PIX_W-1:0]           pixel_index,
	input  logic [blic_pkg::CLS_W-1:0]           class_index,
	input  logic                                 pixel,
	input  logic                                 last_pixel,
	input  logic                                 out_free,
	output logic                                 ready,
	output logic                                 wld_en,
	output logic [WA-1:0]                        wld_addr,
	output logic                                 bld_en,
	output logic [CW-1:0]                        bld_addr,
	output blic_pkg::step_t                      step,
	output logic [WA-1:0]                        waddr,
	output logic                                 emit
);
	import blic_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_ACC   = 5'b00010,
		ST_SCORE = 5'b00100,
		ST_FIN   = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic [WA-1:0]   waddr_q;
	logic            last_q;

	logic [PIX_W+CW:0] row_base;
	logic              pix_ok;
	logic              cls_ok;
	logic              cnt_end;

	assign row_base = pixel_index * (CW+1)'(NUM_CLASSES);
	assign pix_ok   = 32'(pixel_index) < 32'(NPIX);
	assign cls_ok   = 32'(class_index) < 32'(NUM_CLASSES);
	assign cnt_end  = cnt_q == CW'(NUM_CLASSES - 1);

	always_comb begin
		ready      = state_q == ST_IDLE;
		wld_en     = accept && (op == OP_LOAD_WEIGHT) && pix_ok && cls_ok;
		wld_addr   = WA'(row_base) + WA'(class_index);
		bld_en     = accept && (op == OP_LOAD_BIAS) && cls_ok;
		bld_addr   = class_index[CW-1:0];
		step.issue = (state_q == ST_ACC) || (state_q == ST_SCORE);
		step.score = state_q == ST_SCORE;
		step.cls   = CLS_W'(cnt_q);
		waddr      = waddr_q;
		emit       = (state_q == ST_EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			waddr_q <= '0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && op == OP_PIXEL) begin
						last_q <= last_pixel;
						cnt_q  <= '0;
						if (pixel && pix_ok) begin
							waddr_q <= WA'(row_base);
							state_q <= ST_ACC;
						end else if (last_pixel) begin
							state_q <= ST_SCORE;
						end
					end
				end
				ST_ACC: begin
					cnt_q   <= cnt_q + 1'b1;
					waddr_q <= waddr_q + 1'b1;
					if (cnt_end) begin
						cnt_q   <= '0;
						state_q <= last_q ? ST_SCORE : ST_IDLE;
					end
				end
				ST_SCORE: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_end) begin
						cnt_q   <= '0;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench of the binary image linear classifier: fills the weight
// and bias tables, sends directed and random pixel images over the input
// stream, predicts each class word and compares it on the output
// ----------------------------------------------------------------------------
module testbench;

	import blic_pkg::*;

	localparam int NPIX       = IMAGE_WIDTH_DEF * IMAGE_HEIGHT_DEF;
	localparam int NCLS       = NUM_CLASSES_DEF;
	localparam int ACC_HI     = (1 << (ACC_W - 1)) - 1;
	localparam int ACC_LO     = -(1 << (ACC_W - 1));
	localparam int RAND_WORDS = 320;
	localparam int TAIL_WORDS = 100;
	localparam int LONG_HOLD  = 1500;
	localparam int SETTLE     = 160;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// one input word as queued for the driver
	typedef struct packed {
		logic                    drain_first;
		logic [OP_W-1:0]         opcode;
		logic [PIX_W-1:0]        pix;
		logic [CLS_W-1:0]        cls;
		logic signed [VAL_W-1:0] val;
		logic                    pix_on;
		logic                    last;
	} word_t;

	// one predicted result word
	typedef struct packed {
		logic [CLS_W-1:0]   code;
		logic [LABEL_W-1:0] label;
	} verdict_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [S_DATA_W-1:0]   s_axis_tdata = '0;
	logic [OP_W-1:0]       s_axis_tuser = '0;
	logic                  s_axis_tlast = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0]   m_axis_tdata;

	// predictor state
	logic signed [VAL_W-1:0] weight_mem [NPIX*NCLS];
	logic signed [VAL_W-1:0] bias_mem [NCLS];
	logic signed [ACC_W-1:0] acc_mem [NCLS];

	word_t    word_queue[$];
	verdict_t pending_classes[$];

	// generator bookkeeping: which weight entries are written
	bit wt_written [NPIX*NCLS];
	int row_fill [NPIX];
	int pool_rows [8] = '{0, 37, 100, 144, 200, 255, 256, 287};
	bit drain_next;
	int effective_words;
	int image_count;
	int drain_count;

	// run bookkeeping
	bit       word_taken;
	int       tx_idle, rx_idle, hold_left;
	bit       tx_calm, rx_calm, long_hold_done;
	int       fail_count, results_seen, words_sent;
	word_t    acc_word;
	verdict_t want;
	logic [CLS_W-1:0]   got_code;
	logic [LABEL_W-1:0] got_label;

	binary_image_linear_classifier_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ascii label: digits, then letters skipping I and O
	function automatic logic [LABEL_W-1:0] ascii_of_class(input int code);
		if (code < 10)
			return CH_0 + LABEL_W'(code);
		if (code < 18)
			return CH_A + LABEL_W'(code - 10);
		if (code < 23)
			return CH_J + LABEL_W'(code - 18);
		if (code < 34)
			return CH_P + LABEL_W'(code - 23);
		return '0;
	endfunction

	// tables, saturating accumulation and argmax with ties to the lowest class
	task automatic accumulate_and_classify(input word_t w);
		int sum, score, best, best_cls, base;
		verdict_t v;
		case (w.opcode)
			OP_LOAD_WEIGHT: begin
				if (int'(w.pix) < NPIX && int'(w.cls) < NCLS)
					weight_mem[int'(w.pix) * NCLS + int'(w.cls)] = w.val;
			end
			OP_LOAD_BIAS: begin
				if (int'(w.cls) < NCLS)
					bias_mem[w.cls] = w.val;
			end
			OP_PIXEL: begin
				if (w.pix_on && int'(w.pix) < NPIX) begin
					base = int'(w.pix) * NCLS;
					for (int c = 0; c < NCLS; c++) begin
						sum = int'(acc_mem[c]) + int'(weight_mem[base + c]);
						if (sum > ACC_HI)
							sum = ACC_HI;
						else if (sum < ACC_LO)
							sum = ACC_LO;
						acc_mem[c] = sum[ACC_W-1:0];
					end
				end
				if (w.last) begin
					best = int'(acc_mem[0]) + int'(bias_mem[0]);
					best_cls = 0;
					for (int c = 1; c < NCLS; c++) begin
						score = int'(acc_mem[c]) + int'(bias_mem[c]);
						if (score > best) begin
							best = score;
							best_cls = c;
						end
					end
					for (int c = 0; c < NCLS; c++)
						acc_mem[c] = '0;
					v.code = CLS_W'(best_cls);
					v.label = ascii_of_class(best_cls);
					pending_classes.push_back(v);
				end
			end
			default: ;
		endcase
	endtask

	// queue one word and track which weight rows are complete
	task automatic push_word(input logic [OP_W-1:0] opcode, input int pix, input int cls,
			input int val, input bit pix_on, input bit last);
		word_t w;
		w.drain_first = drain_next;
		w.opcode = opcode;
		w.pix = PIX_W'(pix);
		w.cls = CLS_W'(cls);
		w.val = VAL_W'(val);
		w.pix_on = pix_on;
		w.last = last;
		drain_next = 1'b0;
		word_queue.push_back(w);
		if (opcode == OP_PIXEL) begin
			effective_words++;
			if (last)
				image_count++;
		end else if (opcode == OP_LOAD_BIAS && cls < NCLS) begin
			effective_words++;
		end else if (opcode == OP_LOAD_WEIGHT && pix < NPIX && cls < NCLS) begin
			effective_words++;
			if (!wt_written[pix * NCLS + cls]) begin
				wt_written[pix * NCLS + cls] = 1'b1;
				row_fill[pix]++;
			end
		end
	endtask

	// stimulus and run control
	initial begin
		int n, sel, pix, iter, rand_base;
		bit on;

		// table fill: all biases, and the weight rows of the pixel pool
		for (int c = 0; c < NCLS; c++)
			push_word(OP_LOAD_BIAS, $urandom_range(0, 511), c, 0, $urandom_range(0, 1),
				$urandom_range(0, 1));
		foreach (pool_rows[r])
			for (int c = 0; c < NCLS; c++)
				push_word(OP_LOAD_WEIGHT, pool_rows[r], c, $urandom(), $urandom_range(0, 1),
					$urandom_range(0, 1));

		// directed: all scores equal, the tie goes to class 0
		push_word(OP_PIXEL, 5, 0, 0, 1'b0, 1'b1);
		// pixel outside the image still classifies
		push_word(OP_LOAD_BIAS, 0, NCLS - 1, 1, 1'b0, 1'b0);
		push_word(OP_PIXEL, 511, 63, -1, 1'b1, 1'b1);
		// loads with an index out of range are dropped, then two in-range weights of the last pixel
		push_word(OP_LOAD_BIAS, 0, 63, 32767, 1'b1, 1'b0);
		push_word(OP_LOAD_WEIGHT, 511, 0, 32767, 1'b0, 1'b0);
		push_word(OP_LOAD_WEIGHT, 0, 34, 32767, 1'b1, 1'b1);
		push_word(OP_LOAD_WEIGHT, NPIX - 1, NCLS - 1, -32768, 1'b0, 1'b0);
		push_word(OP_LOAD_WEIGHT, NPIX - 1, 0, 32767, 1'b1, 1'b0);
		// unused operation and a load carrying tlast give no word
		push_word(OP_UNUSED, 300, 20, 12345, 1'b1, 1'b1);
		push_word(OP_LOAD_BIAS, 0, 32, -32768, 1'b0, 1'b1);
		// image with both corner pixels set, last pixel cleared
		push_word(OP_PIXEL, 0, 0, 0, 1'b1, 1'b0);
		push_word(OP_PIXEL, NPIX - 1, 33, -32768, 1'b1, 1'b0);
		push_word(OP_PIXEL, 256, 0, 0, 1'b0, 1'b1);
		// bias alone decides, then a tie between two letter classes
		push_word(OP_LOAD_BIAS, 0, 10, 32767, 1'b0, 1'b0);
		push_word(OP_LOAD_BIAS, 0, NCLS - 1, 0, 1'b0, 1'b0);
		push_word(OP_PIXEL, 300, 0, 0, 1'b0, 1'b1);
		push_word(OP_LOAD_BIAS, 0, 17, 32767, 1'b0, 1'b0);
		push_word(OP_PIXEL, 7, 0, 0, 1'b0, 1'b1);
		push_word(OP_LOAD_BIAS, 0, 10, -32768, 1'b0, 1'b0);
		push_word(OP_PIXEL, 8, 0, 0, 1'b0, 1'b1);

		// random part: fresh biases, then mostly short images with noise in between
		drain_next = 1'b1;
		drain_count++;
		for (int c = 0; c < NCLS; c++)
			push_word(OP_LOAD_BIAS, 0, c, $urandom(), 1'b0, 1'b0);
		rand_base = effective_words;
		iter = 0;
		while (effective_words - rand_base < RAND_WORDS) begin
			sel = $urandom_range(0, 99);
			if (sel < 55) begin
				n = $urandom_range(1, 8);
				for (int k = 0; k < n; k++) begin
					// a load slipped into the middle of an image
					if ($urandom_range(0, 9) == 0)
						push_word(OP_LOAD_BIAS, $urandom_range(0, 511), $urandom_range(0, NCLS - 1),
							$urandom(), $urandom_range(0, 1), $urandom_range(0, 1));
					sel = $urandom_range(0, 99);
					if (sel < 60) begin
						pix = pool_rows[$urandom_range(0, 7)];
						on = $urandom_range(0, 1);
					end else if (sel < 85) begin
						pix = $urandom_range(0, NPIX - 1);
						on = (row_fill[pix] == NCLS) ? $urandom_range(0, 1) : 1'b0;
					end else begin
						pix = $urandom_range(NPIX, 511);
						on = $urandom_range(0, 1);
					end
					push_word(OP_PIXEL, pix, $urandom_range(0, 63), $urandom(), on, k == n - 1);
				end
			end else if (sel < 70) begin
				push_word(OP_LOAD_BIAS, $urandom_range(0, 511), $urandom_range(0, NCLS - 1),
					$urandom(), $urandom_range(0, 1), $urandom_range(0, 1));
			end else if (sel < 85) begin
				pix = ($urandom_range(0, 9) < 7) ? pool_rows[$urandom_range(0, 7)]
					: $urandom_range(0, NPIX - 1);
				push_word(OP_LOAD_WEIGHT, pix, $urandom_range(0, NCLS - 1), $urandom(),
					$urandom_range(0, 1), $urandom_range(0, 1));
			end else begin
				case ($urandom_range(0, 2))
					0: push_word(OP_UNUSED, $urandom_range(0, 511), $urandom_range(0, 63),
						$urandom(), $urandom_range(0, 1), $urandom_range(0, 1));
					1: push_word(OP_LOAD_WEIGHT, $urandom_range(NPIX, 511), $urandom_range(0, 63),
						$urandom(), $urandom_range(0, 1), $urandom_range(0, 1));
					default: push_word(OP_LOAD_BIAS, $urandom_range(0, 511),
						$urandom_range(NCLS, 63), $urandom(), $urandom_range(0, 1),
						$urandom_range(0, 1));
				endcase
			end
			iter++;
			if (iter % 100 == 0) begin
				drain_next = 1'b1;
				drain_count++;
			end
		end

		// reset once, released away from the rising edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (word_queue.size() != 0 || pending_classes.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("sent %0d words in %0d images; %0d results checked",
			words_sent, image_count, results_seen);
		$display("output held off %0d cycles once, input paused for the output %0d times",
			LONG_HOLD, drain_count);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// sender: next word at the falling edge once the current one is taken
	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 199) == 0)
				tx_calm = !tx_calm;
			if (!s_axis_tvalid || word_taken) begin
				word_taken = 1'b0;
				if (tx_idle > 0) begin
					tx_idle--;
					s_axis_tvalid <= 1'b0;
				end else if (word_queue.size() == 0) begin
					s_axis_tvalid <= 1'b0;
				end else if (word_queue[0].drain_first && pending_classes.size() != 0) begin
					// pause until every predicted word has come out
					s_axis_tvalid <= 1'b0;
				end else if (!tx_calm && word_queue.size() > TAIL_WORDS
						&& $urandom_range(0, 5) == 0) begin
					tx_idle = $urandom_range(0, 2);
					s_axis_tvalid <= 1'b0;
				end else begin
					s_axis_tdata <= {word_queue[0].pix_on, word_queue[0].val, word_queue[0].cls,
						word_queue[0].pix};
					s_axis_tuser <= word_queue[0].opcode;
					s_axis_tlast <= word_queue[0].last;
					s_axis_tvalid <= 1'b1;
				end
			end
		end
	end

	// receiver ready: short random bursts and one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if ($urandom_range(0, 149) == 0)
				rx_calm = !rx_calm;
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (!long_hold_done && results_seen >= 25) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				m_axis_tready <= 1'b0;
			end else if (rx_idle > 0) begin
				rx_idle--;
				m_axis_tready <= 1'b0;
			end else if (!rx_calm && word_queue.size() > TAIL_WORDS
					&& $urandom_range(0, 5) == 0) begin
				rx_idle = $urandom_range(0, 2);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// rising edge: predict accepted input words, check accepted result words
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				acc_word = word_queue.pop_front();
				accumulate_and_classify(acc_word);
				word_taken = 1'b1;
				words_sent++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got_code = m_axis_tdata[CLS_W-1:0];
				got_label = m_axis_tdata[CLS_W+LABEL_W-1:CLS_W];
				results_seen++;
				if (pending_classes.size() == 0) begin
					$display("%0t: result word %h with none expected", $time, m_axis_tdata);
					fail_count++;
				end else begin
					want = pending_classes.pop_front();
					if (got_code !== want.code) begin
						$display("%0t: class_code expected %0d got %0d", $time, want.code, got_code);
						fail_count++;
					end
					if (got_label !== want.label) begin
						$display("%0t: label_char expected %h got %h", $time, want.label, got_label);
						fail_count++;
					end
				end
			end
		end
	end

	// watchdog
	initial begin
		#3000000;
		$display("%0t: timeout, %0d words and %0d results outstanding", $time,
			word_queue.size(), pending_classes.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
